// ===== rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, constants and the CRC7 byte update for the SD SPI command
// engine.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam logic [7:0] MAX_POLLS_RESET = 8'd52;
    localparam logic [7:0] IDLE_BYTE       = 8'hFF;
    localparam logic [1:0] START_TX_BITS   = 2'b01;
    localparam logic [6:0] CRC7_POLY       = 7'h09;

    // Frame byte positions within a command request
    localparam logic [2:0] FRAME_ARG_LAST = 3'd4;
    localparam logic [2:0] FRAME_END      = 3'd5;
    localparam logic [2:0] FRAME_POLL     = 3'd6;

    localparam logic       MODE_COMMAND = 1'b0;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_POLL,
        JOB_RESP
    } job_kind_t;

    // One queued job, passed from the front to the back
    typedef struct packed {
        job_kind_t   kind;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic        crc_select;
        logic [7:0]  end_byte;
        logic [7:0]  rx_byte;
        logic        timed_out;
    } job_t;

    // CRC7 (x^7+x^3+1) advanced over one byte, MSB first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                             input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int b = 7; b >= 0; b--) begin
            fb  = crc[6] ^ data[b];
            crc = {crc[5:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC7_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/sdc_front.sv =====
// ----------------------------------------------------------------------------
// sdc_front
// Accepts requests, tracks the response wait and turns each request into
// a job for the back end (or drops a received byte when nothing waits).
// ----------------------------------------------------------------------------
module sdc_front
    import sdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [5:0]  s_cmd_index,
    input  logic [31:0] s_argument,
    input  logic        s_crc_select,
    input  logic [7:0]  s_end_byte,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  max_polls,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic       waiting_reg,    waiting_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic       accept;
    logic       ends_wait;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Wait ends on a real response or once the poll budget is spent
    assign ends_wait = (s_rx_byte != IDLE_BYTE) || (poll_count_reg >= max_polls);

    // Classify the request
    always_comb begin
        waiting_next    = waiting_reg;
        poll_count_next = poll_count_reg;
        q_push          = 1'b0;
        q_job.kind       = JOB_CMD;
        q_job.cmd_index  = s_cmd_index;
        q_job.argument   = s_argument;
        q_job.crc_select = s_crc_select;
        q_job.end_byte   = s_end_byte;
        q_job.rx_byte    = s_rx_byte;
        q_job.timed_out  = (s_rx_byte == IDLE_BYTE);
        if (accept) begin
            if (s_mode == MODE_COMMAND) begin
                q_push          = 1'b1;
                waiting_next    = 1'b1;
                poll_count_next = 8'd1;
            end else if (waiting_reg) begin
                q_push = 1'b1;
                if (ends_wait) begin
                    q_job.kind   = JOB_RESP;
                    waiting_next = 1'b0;
                end else begin
                    q_job.kind = JOB_POLL;
                    if (poll_count_reg != 8'hFF) begin
                        poll_count_next = poll_count_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg    <= 1'b0;
            poll_count_reg <= 8'd0;
        end else begin
            waiting_reg    <= waiting_next;
            poll_count_reg <= poll_count_next;
        end
    end

endmodule

// ===== rtl/sdc_queue.sv =====
// ----------------------------------------------------------------------------
// sdc_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sdc_queue
    import sdc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/sdc_back.sv =====
// ----------------------------------------------------------------------------
// sdc_back
// Carries out queued jobs: sends the command frame byte by byte with a
// running CRC7, poll bytes and the response clocking byte, through a
// registered output stage.
// ----------------------------------------------------------------------------
module sdc_back
    import sdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic [7:0] m_response,
    output logic       m_response_valid,
    output logic       m_timed_out,
    output logic       m_last
);

    logic       busy_reg,  busy_next;
    logic [2:0] step_reg,  step_next;
    logic [6:0] crc_reg,   crc_next;
    job_t       job_reg,   job_next;

    logic       m_valid_reg;
    logic [7:0] tx_reg, resp_reg;
    logic       resp_valid_reg, timed_out_reg, last_reg;

    logic       out_free;
    logic       emit;
    logic [7:0] tx_byte;
    logic [7:0] resp_byte;
    logic       resp_valid;
    logic       timed_out;
    logic       last;
    logic [7:0] first_byte;

    assign out_free   = !m_valid_reg || m_ready;
    assign first_byte = {START_TX_BITS, q_head.cmd_index};

    // Job sequencer
    always_comb begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        crc_next   = crc_reg;
        job_next   = job_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        tx_byte    = IDLE_BYTE;
        resp_byte  = 8'd0;
        resp_valid = 1'b0;
        timed_out  = 1'b0;
        last       = 1'b0;
        if (busy_reg) begin
            if (out_free) begin
                emit      = 1'b1;
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1:      tx_byte = job_reg.argument[31:24];
                    3'd2:      tx_byte = job_reg.argument[23:16];
                    3'd3:      tx_byte = job_reg.argument[15:8];
                    3'd4:      tx_byte = job_reg.argument[7:0];
                    FRAME_END: tx_byte = job_reg.crc_select ?
                                         (job_reg.end_byte | 8'h01) : {crc_reg, 1'b1};
                    default:   tx_byte = IDLE_BYTE;
                endcase
                if (step_reg <= FRAME_ARG_LAST) begin
                    crc_next = crc7_byte(crc_reg, tx_byte);
                end
                if (step_reg == FRAME_POLL) begin
                    last      = 1'b1;
                    busy_next = 1'b0;
                end
            end
        end else if (q_not_empty && out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            unique case (q_head.kind)
                JOB_CMD: begin
                    tx_byte   = first_byte;
                    job_next  = q_head;
                    crc_next  = crc7_byte(7'd0, first_byte);
                    step_next = 3'd1;
                    busy_next = 1'b1;
                end
                JOB_POLL: begin
                    last = 1'b1;
                end
                JOB_RESP: begin
                    resp_byte  = q_head.rx_byte;
                    resp_valid = 1'b1;
                    timed_out  = q_head.timed_out;
                    last       = 1'b1;
                end
                default: begin
                    last = 1'b1;
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        job_reg <= job_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            tx_reg         <= tx_byte;
            resp_reg       <= resp_byte;
            resp_valid_reg <= resp_valid;
            timed_out_reg  <= timed_out;
            last_reg       <= last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_tx_byte        = tx_reg;
    assign m_response       = resp_reg;
    assign m_response_valid = resp_valid_reg;
    assign m_timed_out      = timed_out_reg;
    assign m_last           = last_reg;

endmodule

// ===== rtl/sd_spi_command_engine_top.sv =====
// ----------------------------------------------------------------------------
// sd_spi_command_engine_top
// SD-card SPI-mode command engine: command frame with CRC7, response polling
// and R1 capture.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   s_      | in        | s_valid/s_ready, mode, index, argument, crc, rx
//   m_      | out       | m_valid/m_ready, tx byte, response, flags, last
//   cfg_    | in        | cfg_valid/cfg_ready, cfg_max_polls
//
// A command request yields seven result bytes; a poll or response request
// made while a response is awaited yields one byte. The back end's byte
// sequencer produces these bytes; a two-entry job queue lets the front keep
// taking requests meanwhile. Synchronous active-low reset clears the wait
// state, the queue and the output register; max_polls returns to 52. A
// stalled m_ready holds the output byte and backs up through the queue.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_top
    import sdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [5:0]  s_cmd_index,
    input  logic [31:0] s_argument,
    input  logic        s_crc_select,
    input  logic [7:0]  s_end_byte,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic [7:0]  m_response,
    output logic        m_response_valid,
    output logic        m_timed_out,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_max_polls
);

    logic [7:0] max_polls_reg;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    job_t       q_job;
    job_t       q_head;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_polls_reg <= MAX_POLLS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_polls_reg <= cfg_max_polls;
        end
    end

    sdc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_cmd_index  (s_cmd_index),
        .s_argument   (s_argument),
        .s_crc_select (s_crc_select),
        .s_end_byte   (s_end_byte),
        .s_rx_byte    (s_rx_byte),
        .max_polls    (max_polls_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    sdc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (q_head)
    );

    sdc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_not_empty      (q_not_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_byte        (m_tx_byte),
        .m_response       (m_response),
        .m_response_valid (m_response_valid),
        .m_timed_out      (m_timed_out),
        .m_last           (m_last)
    );

    // A response always closes its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_response_valid |-> m_last)
        else $error("response byte without last");

    // Timeout is only reported with an all-ones response
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timed_out |-> m_response_valid && (m_response == IDLE_BYTE))
        else $error("timeout flag without idle response");

    // Every response and poll byte sent on the line is all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_tx_byte == IDLE_BYTE)
        else $error("last byte is not a clocking byte");

    // The queue is never pushed while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("push into full job queue");

endmodule
